// ===== rtl/hamming_encoder_variable_length_top_macros.svh =====
// Assertion macros used by the checker in hme_checker.sv.
`ifndef HAMMING_ENCODER_VARIABLE_LENGTH_TOP_MACROS_SVH
`define HAMMING_ENCODER_VARIABLE_LENGTH_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HME_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hme check failed");

// Implication checked on the following clock edge, live through reset.
`define HME_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("hme check failed");

`endif

// ===== rtl/hme_pkg.sv =====
package hme_pkg;

   localparam int DATA_W           = 57;
   localparam int LEN_W            = 6;
   localparam int CODE_W           = 63;
   localparam int PAR_W            = 6;
   localparam int CNT_W            = 3;
   localparam int DATA_MAX_DEFAULT = 57;

   // Request word: message and its length
   typedef struct packed {
      logic [DATA_W-1:0] data_word;
      logic [LEN_W-1:0]  data_bits;
   } req_type;

   // Response word: codeword and its length
   typedef struct packed {
      logic [CODE_W-1:0] codeword;
      logic [LEN_W-1:0]  code_length;
   } rsp_type;

   // Codeword bit index that carries data bit k (skips power-of-two positions)
   function automatic logic [LEN_W-1:0] data_pos(input int k);
      int               cnt;
      logic [LEN_W-1:0] res;
      cnt = 0;
      res = '0;
      for (int pos = 1; pos <= CODE_W; pos++) begin
         if ((pos & (pos - 1)) != 0) begin
            if (cnt == k) res = LEN_W'(pos - 1);
            cnt++;
         end
      end
      return res;
   endfunction

   // Codeword bits covered by check bit j
   function automatic logic [CODE_W-1:0] cover_mask(input int j);
      logic [CODE_W-1:0] res;
      res = '0;
      for (int i = 0; i < CODE_W; i++) begin
         res[i] = (((i + 1) >> j) & 1) != 0;
      end
      return res;
   endfunction

   // Least p with 2^p >= p + m + 1, for m in 1..57
   function automatic logic [CNT_W-1:0] check_count(input logic [LEN_W-1:0] m);
      logic [CNT_W-1:0] res;
      if (m <= LEN_W'(1))       res = CNT_W'(2);
      else if (m <= LEN_W'(4))  res = CNT_W'(3);
      else if (m <= LEN_W'(11)) res = CNT_W'(4);
      else if (m <= LEN_W'(26)) res = CNT_W'(5);
      else                      res = CNT_W'(6);
      return res;
   endfunction

endpackage

// ===== rtl/hme_encode.sv =====
module hme_encode #(
   parameter int DATA_MAX = hme_pkg::DATA_MAX_DEFAULT
) (
   input  hme_pkg::req_type req,
   input  logic             even_parity,
   output hme_pkg::rsp_type rsp
);
   import hme_pkg::*;

   localparam logic [LEN_W-1:0] MaxLen = LEN_W'(DATA_MAX);

   logic [LEN_W-1:0]  m_len;
   logic [CNT_W-1:0]  p_cnt;
   logic [CODE_W-1:0] scatter;
   logic [CODE_W-1:0] code;
   logic              par;

   // clamp the length into 1..DATA_MAX
   always_comb begin
      if (req.data_bits == '0)       m_len = LEN_W'(1);
      else if (req.data_bits > MaxLen) m_len = MaxLen;
      else                           m_len = req.data_bits;
   end

   assign p_cnt = check_count(m_len);

   // place masked data bits at the non-power-of-two positions
   always_comb begin
      scatter = '0;
      for (int k = 0; k < DATA_W; k++) begin
         scatter[data_pos(k)] = req.data_word[k] & (LEN_W'(k) < m_len);
      end
   end

   // check bits: one XOR tree each, only the first p are used
   always_comb begin
      code = scatter;
      par  = 1'b0;
      for (int j = 0; j < PAR_W; j++) begin
         par = (^(scatter & cover_mask(j))) ^ ~even_parity;
         if (CNT_W'(j) < p_cnt) code[LEN_W'((1 << j) - 1)] = par;
      end
   end

   assign rsp.codeword    = code;
   assign rsp.code_length = m_len + {{(LEN_W-CNT_W){1'b0}}, p_cnt};

endmodule

// ===== rtl/hamming_encoder_variable_length_top.sv =====
// Channel   | Ports                       | Handshake
// ----------+-----------------------------+------------------------------------
// request   | start, busy, req_word       | taken when start high and busy low
// response  | rsp_strobe, rsp_word        | one-cycle strobe, no back-pressure
// control   | csr_write, csr_data         | even_parity written when csr_write
//
// Datapath: input register, XOR trees, result register.
// A word is taken every cycle; busy is always low.
// Synchronous reset clears the valid flags and sets even parity.
// The receiver cannot stall, so nothing is held back at the output.
module hamming_encoder_variable_length_top #(
   parameter int DATA_MAX = hme_pkg::DATA_MAX_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hme_pkg::req_type req_word,
   output logic             rsp_strobe,
   output hme_pkg::rsp_type rsp_word,
   input  logic             csr_write,
   input  logic             csr_data
);
   import hme_pkg::*;

   req_type req_ff;
   logic    req_valid_ff, req_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_strobe_ff;
   logic    even_parity_ff, even_parity_in;

   assign busy         = 1'b0;
   assign req_valid_in = start & ~busy;
   assign even_parity_in = csr_write ? csr_data : even_parity_ff;

   // parity mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         even_parity_ff <= 1'b1;
      end else begin
         even_parity_ff <= even_parity_in;
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      if (req_valid_in) req_ff <= req_word;
   end

   hme_encode #(
      .DATA_MAX(DATA_MAX)
   ) u_encode (
      .req         (req_ff),
      .even_parity (even_parity_ff),
      .rsp         (rsp_in)
   );

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= req_valid_ff;
      end
      if (req_valid_ff) rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ===== rtl/hme_checker.sv =====
`include "hamming_encoder_variable_length_top_macros.svh"

module hme_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input hme_pkg::rsp_type rsp_word
);
   import hme_pkg::*;

   // no response word straight after reset
   `HME_ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_strobe)

   // one response per taken word, through the input and result registers
   `HME_ASSERT_IMPL(a_latency, clock, reset, !$past(reset, 1) && !$past(reset, 2), rsp_strobe == $past(start && !busy, 2))

   // codeword is clear above its length
   `HME_ASSERT_IMPL(a_upper_zero, clock, reset, rsp_strobe, (rsp_word.codeword >> rsp_word.code_length) == '0)

   // a code has at least one data and two check bits
   `HME_ASSERT_IMPL(a_min_length, clock, reset, rsp_strobe, rsp_word.code_length >= LEN_W'(3))

endmodule

bind hamming_encoder_variable_length_top hme_checker u_checker (.*);

// ===== dv/hme_codeword_checker.sv =====
// Watches the request, response and control ports of the Hamming encoder.
// Works out each codeword from the accepted request and compares it with
// the responses in order.
module hme_codeword_checker #(
   parameter int DATA_MAX = hme_pkg::DATA_MAX_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  hme_pkg::req_type req_word,
   input  logic             rsp_strobe,
   input  hme_pkg::rsp_type rsp_word,
   input  logic             csr_write,
   input  logic             csr_data,
   output int               errors,
   output int               pending
);
   import hme_pkg::*;

   rsp_type expected_codes[$];
   rsp_type oldest;
   bit      even_mode;

   // Hamming codeword of one request word under the given parity mode
   function automatic rsp_type encode_word(input req_type w, input bit even);
      int                m;
      int                p;
      int                n;
      int                k;
      logic [CODE_W-1:0] code;
      logic              par;
      rsp_type           r;
      m = int'(w.data_bits);
      if (m < 1) m = 1;
      if (m > DATA_MAX) m = DATA_MAX;
      p = 0;
      while ((1 << p) < p + m + 1) p++;
      n = m + p;
      code = '0;
      k = 0;
      // message bits into the non power-of-two positions, lowest first
      for (int pos = 1; pos <= n; pos++) begin
         if ((pos & (pos - 1)) != 0) begin
            code[pos-1] = w.data_word[k];
            k++;
         end
      end
      // check bit j covers every position with bit j of its index set
      for (int j = 0; j < p; j++) begin
         par = 1'b0;
         for (int pos = 1; pos <= n; pos++) begin
            if (((pos >> j) & 1) != 0) par = par ^ code[pos-1];
         end
         if (!even) par = ~par;
         code[(1 << j) - 1] = par;
      end
      r.codeword    = code;
      r.code_length = LEN_W'(n);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_codes.delete();
         even_mode = 1'b1;
      end else begin
         // response side: one word per strobe, no hold-off
         if (rsp_strobe) begin
            if (expected_codes.size() == 0) begin
               errors++;
               $display("%0t unexpected response: expected none, got codeword %h length %0d",
                        $time, rsp_word.codeword, rsp_word.code_length);
            end else begin
               oldest = expected_codes.pop_front();
               if (rsp_word.codeword !== oldest.codeword) begin
                  errors++;
                  $display("%0t codeword mismatch: expected %h, got %h",
                           $time, oldest.codeword, rsp_word.codeword);
               end
               if (rsp_word.code_length !== oldest.code_length) begin
                  errors++;
                  $display("%0t code length mismatch: expected %0d, got %0d",
                           $time, oldest.code_length, rsp_word.code_length);
               end
            end
         end
         // request side
         if (start && !busy) begin
            expected_codes.insert(expected_codes.size(), encode_word(req_word, even_mode));
         end
         // parity mode; the bench must write it only while idle, this checker does not enforce that
         if (csr_write) even_mode = csr_data;
      end
      pending = expected_codes.size();
   end

endmodule

// ===== dv/tb.sv =====
module tb;
   import hme_pkg::*;

   localparam int LATENCY = 2;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   logic    csr_write = 1'b0;
   logic    csr_data  = 1'b0;
   req_type req_word  = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_word;
   int      errors;
   int      pending;

   always #6 clock = ~clock;

   hamming_encoder_variable_length_top DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_write  (csr_write),
      .csr_data   (csr_data)
   );

   hme_codeword_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_write  (csr_write),
      .csr_data   (csr_data),
      .errors     (errors),
      .pending    (pending)
   );

   // Offer one word after a random gap; returns once it is taken
   task automatic send_word(input req_type w, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
   endtask

   // Random message, now and then with an out-of-range length
   function automatic req_type random_word();
      req_type w;
      int      pick;
      w.data_word = DATA_W'({$urandom, $urandom});
      pick = $urandom_range(99);
      if (pick < 4) w.data_bits = '0;
      else if (pick < 10) w.data_bits = LEN_W'($urandom_range(63, 58));
      else w.data_bits = LEN_W'($urandom_range(57, 1));
      return w;
   endfunction

   // Stop sending and wait until every expected word is back
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_parity(input logic even);
      drain();
      csr_write <= 1'b1;
      csr_data  <= even;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic random_phase(input int count, input int idle_pct);
      for (int i = 0; i < count; i++) begin
         // hold off now and then until the pipe is empty
         if (i > 0 && i % 150 == 0) drain();
         send_word(random_word(), idle_pct);
      end
   endtask

   // Directed lengths: zero, boundaries of the check-bit count, top, above top
   task automatic directed_words();
      int      lens[12] = '{0, 1, 2, 4, 5, 11, 12, 26, 27, 57, 58, 63};
      req_type w;
      for (int i = 0; i < 12; i++) begin
         case (i % 3)
            0: w.data_word = '1;
            1: w.data_word = '0;
            default: w.data_word = DATA_W'({$urandom, $urandom});
         endcase
         w.data_bits = LEN_W'(lens[i]);
         send_word(w, 0);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // even parity from reset, then odd
      directed_words();
      write_parity(1'b0);
      directed_words();

      // sender idles sometimes, then often, then never
      random_phase(420, 19);
      write_parity(1'b1);
      random_phase(420, 57);
      write_parity(1'b0);
      random_phase(200, 0);
      write_parity(1'b1);
      random_phase(210, 0);

      drain();
      if (errors == 0 && pending == 0) begin
         $display("PASS hamming_encoder_variable_length_top");
      end else begin
         $display("FAIL hamming_encoder_variable_length_top");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(12 * 200000);
      $display("FAIL hamming_encoder_variable_length_top");
      $finish;
   end

endmodule
